// File: hw/rtl/scf_pkg.sv
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants
// Item formats, op codes, controller states and control/status bundles for
// the second-chance frame replacement unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

  localparam int FRAME_W    = 10;
  localparam int LINK_W     = FRAME_W + 1;
  localparam int FRAMES_DEF = 1024;

  localparam logic [LINK_W-1:0] LINK_NIL = {1'b1, {FRAME_W{1'b0}}};

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_MARK   = 2'd1,
    OP_VICTIM = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [FRAME_W-1:0] frame;
  } scf_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] victim;
    logic               status;
  } scf_out_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DISP,
    S_APP_CHK,
    S_WALK,
    S_EVICT,
    S_CLR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load_item;
    logic init_clr;
    logic res_clear;
    logic res_status;
    logic mark;
    logic app_rd;
    logic app_link;
    logic vic_start;
    logic walk_found;
    logic walk_step;
    logic evict;
    logic unlink_clr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       init_last;
    logic       frame_ok;
    logic       head_nil;
    logic       in_queue;
    logic       acc_zero;
    logic       next_nil;
    logic       out_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/scf_ram.sv
// ----------------------------------------------------------------------------
// scf_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/scf_datapath.sv
// ----------------------------------------------------------------------------
// scf_datapath: queue pointers, link and accessed-bit memories, result regs
// Executes controller commands; reports status flags back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scf_datapath #(
  parameter int FRAMES = scf_pkg::FRAMES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scf_pkg::scf_in_t  in_data_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output scf_pkg::scf_out_t out_data_o,
  input  scf_pkg::cmd_t     cmd_i,
  output scf_pkg::sts_t     sts_o
);

  import scf_pkg::*;

  localparam int AW = $clog2(FRAMES);

  logic [1:0]         op_q;
  logic [FRAME_W-1:0] frame_q;
  logic [LINK_W-1:0]  head_q, head_d;
  logic [LINK_W-1:0]  tail_q, tail_d;
  logic [LINK_W-1:0]  cur_q, cur_d;
  logic [LINK_W-1:0]  prev_q, prev_d;
  logic [LINK_W-1:0]  head_next_q, head_next_d;
  logic               first_q, first_d;
  logic [FRAME_W-1:0] victim_q, victim_d;
  logic               status_q, status_d;
  logic [AW-1:0]      clr_cnt_q;
  logic               out_valid_q;
  scf_out_t           out_q;

  logic               link_we, acc_we;
  logic [AW-1:0]      link_waddr, acc_waddr, raddr;
  logic [LINK_W-1:0]  link_wdata, link_rd;
  logic               acc_wdata, acc_rd;

  scf_ram #(.WIDTH(LINK_W), .DEPTH(FRAMES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (raddr),
    .rdata_o (link_rd)
  );

  scf_ram #(.WIDTH(1), .DEPTH(FRAMES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (raddr),
    .rdata_o (acc_rd)
  );

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    head_next_d = head_next_q;
    first_d     = first_q;
    victim_d    = victim_q;
    status_d    = status_q;
    link_we     = 1'b0;
    link_waddr  = AW'(frame_q);
    link_wdata  = LINK_NIL;
    acc_we      = 1'b0;
    acc_waddr   = AW'(frame_q);
    acc_wdata   = 1'b0;
    raddr       = AW'(frame_q);

    if (cmd_i.init_clr) begin
      link_we    = 1'b1;
      link_waddr = clr_cnt_q;
      acc_we     = 1'b1;
      acc_waddr  = clr_cnt_q;
    end
    if (cmd_i.res_clear) begin
      victim_d = '0;
      status_d = cmd_i.res_status;
    end
    if (cmd_i.mark) begin
      acc_we    = 1'b1;
      acc_wdata = 1'b1;
    end
    if (cmd_i.app_rd) begin
      raddr = AW'(frame_q);
    end
    if (cmd_i.app_link) begin
      if (head_q[FRAME_W]) begin
        head_d = {1'b0, frame_q};
      end else begin
        link_we    = 1'b1;
        link_waddr = AW'(tail_q[FRAME_W-1:0]);
        link_wdata = {1'b0, frame_q};
      end
      tail_d = {1'b0, frame_q};
    end
    if (cmd_i.vic_start) begin
      raddr   = AW'(head_q[FRAME_W-1:0]);
      cur_d   = head_q;
      prev_d  = LINK_NIL;
      first_d = 1'b1;
    end
    if (cmd_i.walk_found) begin
      if (prev_q[FRAME_W]) begin
        head_d = link_rd;
      end else begin
        link_we    = 1'b1;
        link_waddr = AW'(prev_q[FRAME_W-1:0]);
        link_wdata = link_rd;
      end
      if (tail_q == cur_q) begin
        tail_d = prev_q;
      end
      victim_d = cur_q[FRAME_W-1:0];
    end
    if (cmd_i.walk_step) begin
      acc_we    = 1'b1;
      acc_waddr = AW'(cur_q[FRAME_W-1:0]);
      raddr     = AW'(link_rd[FRAME_W-1:0]);
      if (first_q) begin
        head_next_d = link_rd;
      end
      first_d = 1'b0;
      prev_d  = cur_q;
      cur_d   = link_rd;
    end
    if (cmd_i.evict) begin
      link_we    = 1'b1;
      link_waddr = AW'(head_q[FRAME_W-1:0]);
      head_d     = head_next_q;
      if (tail_q == head_q) begin
        tail_d = LINK_NIL;
      end
      victim_d = head_q[FRAME_W-1:0];
    end
    if (cmd_i.unlink_clr) begin
      link_we    = 1'b1;
      link_waddr = AW'(victim_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= LINK_NIL;
      tail_q      <= LINK_NIL;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      first_q <= first_d;
      if (cmd_i.init_clr) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    head_next_q <= head_next_d;
    victim_q    <= victim_d;
    status_q    <= status_d;
    if (cmd_i.load_item) begin
      op_q    <= in_data_i.op;
      frame_q <= in_data_i.frame;
    end
    if (cmd_i.out_load) begin
      out_q.victim <= victim_q;
      out_q.status <= status_q;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.init_last = (clr_cnt_q == AW'(FRAMES - 1));
  assign sts_o.frame_ok  = (int'(frame_q) < FRAMES);
  assign sts_o.head_nil  = head_q[FRAME_W];
  assign sts_o.in_queue  = !link_rd[FRAME_W] || (tail_q == {1'b0, frame_q});
  assign sts_o.acc_zero  = !acc_rd;
  assign sts_o.next_nil  = link_rd[FRAME_W];
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/scf_ctrl.sv
// ----------------------------------------------------------------------------
// scf_ctrl: sequencing state machine
// Clears memories after reset, dispatches items and steps the victim walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  scf_pkg::sts_t sts_i,
  output scf_pkg::cmd_t cmd_o
);

  import scf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init_clr = 1'b1;
        if (sts_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.res_clear = 1'b1;
        state_d         = S_RESP;
        if (sts_i.op == OP_APPEND) begin
          if (sts_i.frame_ok) begin
            cmd_o.app_rd = 1'b1;
            state_d      = S_APP_CHK;
          end
        end else if (sts_i.op == OP_MARK) begin
          cmd_o.mark = sts_i.frame_ok;
        end else if (sts_i.op == OP_VICTIM) begin
          if (sts_i.head_nil) begin
            cmd_o.res_status = 1'b1;
          end else begin
            cmd_o.vic_start = 1'b1;
            state_d         = S_WALK;
          end
        end
      end
      S_APP_CHK: begin
        cmd_o.app_link = !sts_i.in_queue;
        state_d        = S_RESP;
      end
      S_WALK: begin
        if (sts_i.acc_zero) begin
          cmd_o.walk_found = 1'b1;
          state_d          = S_CLR;
        end else begin
          cmd_o.walk_step = 1'b1;
          if (sts_i.next_nil) begin
            state_d = S_EVICT;
          end
        end
      end
      S_EVICT: begin
        cmd_o.evict = 1'b1;
        state_d     = S_RESP;
      end
      S_CLR: begin
        cmd_o.unlink_clr = 1'b1;
        state_d          = S_RESP;
      end
      S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/second_chance_frame_replacement_unit.sv
// ----------------------------------------------------------------------------
// second_chance_frame_replacement_unit: second-chance frame replacement queue
// Input item: op (append, mark accessed, choose victim) and a frame number.
// Output item: one per input item, the evicted frame (zero otherwise) and a
// status bit that flags a victim request on an empty queue.
// Both channels are valid/ready. One item is in work at a time; the next
// item is taken while the previous result still waits in the output
// register.
// A victim request walks the queue from the head, one link-RAM read per
// walk step, until an unaccessed frame is found or every queued frame was
// accessed, passing N accessed frames (up to FRAMES). The result becomes
// valid in the same cycle that the next item can be taken.
// After reset the link and accessed-bit RAMs are cleared, one entry per
// cycle, over all FRAMES entries; in_ready_o stays low during that pass.
// When the receiver stalls, the result holds in the output register and
// the block waits before presenting the following result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module second_chance_frame_replacement_unit #(
  parameter int FRAMES = scf_pkg::FRAMES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  scf_pkg::scf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output scf_pkg::scf_out_t out_data_o
);

  import scf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  scf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scf_datapath #(.FRAMES(FRAMES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while another is in work");

  a_status_no_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |-> (out_data_o.victim == '0))
    else $error("empty-queue status with nonzero victim");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.init_clr |-> !in_ready_o)
    else $error("input ready during memory clear");
`endif

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: second-chance frame replacement unit
// A directed table covers the empty queue, duplicate appends, the unused op
// code, frame extremes and the accessed bit kept across append. Random items
// follow, drawn mostly from a small frame pool so that walks run deep. Every
// result is checked against a typed row value or an in-bench queue model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import scf_pkg::*;

  localparam int          CYCLE_LIMIT  = 3_000_000;
  localparam int          RANDOM_ITEMS = 580;
  localparam int          TAIL_CYCLES  = 16;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  typedef struct packed {
    scf_in_t  item;
    logic     typed;
    scf_out_t res;
  } dir_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  scf_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  scf_out_t out_data_o;

  second_chance_frame_replacement_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // replacement queue model
  logic [LINK_W-1:0] link_q [FRAMES_DEF];
  logic              acc_q  [FRAMES_DEF];
  logic [LINK_W-1:0] head_q;
  logic [LINK_W-1:0] tail_q;

  scf_out_t result_q [$];
  dir_row_t dir_tab [$];
  scf_out_t want_res;

  int mismatch_cnt = 0;
  int sent_cnt     = 0;
  int evict_cnt    = 0;
  int empty_cnt    = 0;
  int deepest_walk = 0;
  int cycle_cnt    = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  function automatic scf_out_t predict_replacement(input scf_in_t item);
    scf_out_t          res;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] nxt;
    logic              found;
    int                steps;
    res = '0;
    case (item.op)
      OP_APPEND: begin
        if (link_q[item.frame][FRAME_W] && tail_q != {1'b0, item.frame}) begin
          link_q[item.frame] = LINK_NIL;
          if (head_q[FRAME_W]) begin
            head_q = {1'b0, item.frame};
          end else begin
            link_q[tail_q[FRAME_W-1:0]] = {1'b0, item.frame};
          end
          tail_q = {1'b0, item.frame};
        end
      end
      OP_MARK: acc_q[item.frame] = 1'b1;
      OP_VICTIM: begin
        if (head_q[FRAME_W]) begin
          res.status = 1'b1;
          empty_cnt++;
        end else begin
          cur   = head_q;
          prev  = LINK_NIL;
          found = 1'b0;
          steps = 0;
          while (!found && !cur[FRAME_W] && steps < FRAMES_DEF) begin
            if (!acc_q[cur[FRAME_W-1:0]]) begin
              found = 1'b1;
            end else begin
              acc_q[cur[FRAME_W-1:0]] = 1'b0;
              prev = cur;
              cur  = link_q[cur[FRAME_W-1:0]];
              steps++;
            end
          end
          // everything was accessed: take the head
          if (!found) begin
            cur  = head_q;
            prev = LINK_NIL;
          end
          nxt = link_q[cur[FRAME_W-1:0]];
          if (prev[FRAME_W]) begin
            head_q = nxt;
          end else begin
            link_q[prev[FRAME_W-1:0]] = nxt;
          end
          if (tail_q == cur) tail_q = prev;
          link_q[cur[FRAME_W-1:0]] = LINK_NIL;
          res.victim = cur[FRAME_W-1:0];
          evict_cnt++;
          if (steps > deepest_walk) deepest_walk = steps;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic add_row(input logic [1:0] op, input logic [FRAME_W-1:0] frame,
                         input logic typed, input logic [FRAME_W-1:0] victim,
                         input logic status);
    dir_row_t row;
    row.item.op    = op;
    row.item.frame = frame;
    row.typed      = typed;
    row.res.victim = victim;
    row.res.status = status;
    dir_tab.push_back(row);
  endtask

  task automatic send_item(input scf_in_t item, input logic typed,
                           input scf_out_t typed_res);
    scf_out_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    res = predict_replacement(item);
    if (typed) res = typed_res;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    result_q.push_back(res);
    sent_cnt++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item: victim %0d status %0d",
                                  out_data_o.victim, out_data_o.status));
      end else begin
        want_res = result_q.pop_front();
        if (out_data_o.victim !== want_res.victim)
          report_mismatch($sformatf("victim %0d, predicted %0d",
                                    out_data_o.victim, want_res.victim));
        if (out_data_o.status !== want_res.status)
          report_mismatch($sformatf("status %0b, predicted %0b",
                                    out_data_o.status, want_res.status));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    scf_in_t  item;
    scf_out_t zero_res;
    int       pick;
    int       phase;
    zero_res    = '0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    for (int i = 0; i < FRAMES_DEF; i++) begin
      link_q[i] = LINK_NIL;
      acc_q[i]  = 1'b0;
    end
    head_q = LINK_NIL;
    tail_q = LINK_NIL;

    add_row(OP_VICTIM, 10'd0,     1'b1, 10'd0, 1'b1);
    add_row(OP_UNUSED, 10'h3FF,   1'b1, 10'd0, 1'b0);
    add_row(OP_APPEND, 10'd0,     1'b1, 10'd0, 1'b0);
    add_row(OP_APPEND, 10'd1023,  1'b1, 10'd0, 1'b0);
    add_row(OP_APPEND, 10'd0,     1'b1, 10'd0, 1'b0);
    add_row(OP_MARK,   10'd0,     1'b1, 10'd0, 1'b0);
    add_row(OP_APPEND, 10'd512,   1'b1, 10'd0, 1'b0);
    add_row(OP_VICTIM, 10'd0,     1'b0, 10'd0, 1'b0);
    add_row(OP_VICTIM, 10'h3FF,   1'b0, 10'd0, 1'b0);
    add_row(OP_MARK,   10'd512,   1'b1, 10'd0, 1'b0);
    add_row(OP_VICTIM, 10'd0,     1'b0, 10'd0, 1'b0);
    add_row(OP_VICTIM, 10'h3FF,   1'b1, 10'd0, 1'b1);
    add_row(OP_MARK,   10'd1023,  1'b1, 10'd0, 1'b0);
    add_row(OP_APPEND, 10'd1023,  1'b1, 10'd0, 1'b0);
    add_row(OP_APPEND, 10'h155,   1'b1, 10'd0, 1'b0);
    add_row(OP_APPEND, 10'h2AA,   1'b1, 10'd0, 1'b0);
    add_row(OP_MARK,   10'h2AA,   1'b1, 10'd0, 1'b0);
    add_row(OP_APPEND, 10'h155,   1'b1, 10'd0, 1'b0);
    add_row(OP_VICTIM, 10'd0,     1'b0, 10'd0, 1'b0);
    add_row(OP_VICTIM, 10'd0,     1'b0, 10'd0, 1'b0);
    add_row(OP_VICTIM, 10'd0,     1'b0, 10'd0, 1'b0);
    add_row(OP_VICTIM, 10'd0,     1'b1, 10'd0, 1'b1);
    add_row(OP_UNUSED, 10'd0,     1'b1, 10'd0, 1'b0);
    add_row(OP_MARK,   10'd0,     1'b1, 10'd0, 1'b0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < dir_tab.size(); i++)
      send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
    wait_drain();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 24; rx_idle_pct = 87; end
        1: begin tx_idle_pct = 87; rx_idle_pct = 24; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        pick = $urandom_range(99);
        if (pick < 38)      item.op = OP_APPEND;
        else if (pick < 68) item.op = OP_MARK;
        else if (pick < 95) item.op = OP_VICTIM;
        else                item.op = OP_UNUSED;
        case ($urandom_range(9))
          0:       item.frame = FRAME_W'($urandom_range(1023));
          1:       item.frame = FRAME_W'(1023 - $urandom_range(15));
          default: item.frame = FRAME_W'($urandom_range(47));
        endcase
        send_item(item, 1'b0, zero_res);
      end
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("summary: %0d items sent, %0d frames evicted, %0d empty-queue requests",
             sent_cnt, evict_cnt, empty_cnt);
    $display("summary: deepest walk passed %0d accessed frames, %0d mismatches",
             deepest_walk, mismatch_cnt);
    if (mismatch_cnt == 0 && result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (result_q.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", result_q.size()));
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/scf_pkg.sv
hw/rtl/scf_ram.sv
hw/rtl/scf_datapath.sv
hw/rtl/scf_ctrl.sv
hw/rtl/second_chance_frame_replacement_unit.sv
dv/testbench.sv
